@@ design/soc_pkg.sv @@
`timescale 1ns / 1ps
package soc_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int KEY_W       = 32;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = 11;
    // signed search bounds: hi may reach -1, lo may reach the depth
    localparam int PTR_W       = IDX_W + 2;
    localparam int STEP_W      = 3;

    typedef logic [STEP_W-1:0] t_step;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_INIT,
        UOP_READ,
        UOP_CMP,
        UOP_SAVE,
        UOP_FIN
    } t_uop;

    typedef enum logic [1:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_DONE,
        JC_QUERY
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step tgt;
        logic  low;
    } t_uword;

    localparam t_step ST_IDLE   = 3'd0;
    localparam t_step ST_INIT   = 3'd1;
    localparam t_step ST_CHK_L  = 3'd2;
    localparam t_step ST_CMP_L  = 3'd3;
    localparam t_step ST_SAVE   = 3'd4;
    localparam t_step ST_CHK_H  = 3'd5;
    localparam t_step ST_CMP_H  = 3'd6;
    localparam t_step ST_FIN    = 3'd7;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        case (step)
            ST_IDLE:  w = '{op: UOP_NOP,  cond: JC_QUERY,  tgt: ST_INIT,  low: 1'b1};
            ST_INIT:  w = '{op: UOP_INIT, cond: JC_NEXT,   tgt: ST_IDLE,  low: 1'b1};
            ST_CHK_L: w = '{op: UOP_READ, cond: JC_DONE,   tgt: ST_SAVE,  low: 1'b1};
            ST_CMP_L: w = '{op: UOP_CMP,  cond: JC_ALWAYS, tgt: ST_CHK_L, low: 1'b1};
            ST_SAVE:  w = '{op: UOP_SAVE, cond: JC_NEXT,   tgt: ST_IDLE,  low: 1'b0};
            ST_CHK_H: w = '{op: UOP_READ, cond: JC_DONE,   tgt: ST_FIN,   low: 1'b0};
            ST_CMP_H: w = '{op: UOP_CMP,  cond: JC_ALWAYS, tgt: ST_CHK_H, low: 1'b0};
            ST_FIN:   w = '{op: UOP_FIN,  cond: JC_ALWAYS, tgt: ST_IDLE,  low: 1'b0};
            default:  w = '{op: UOP_NOP,  cond: JC_ALWAYS, tgt: ST_IDLE,  low: 1'b0};
        endcase
        return w;
    endfunction

endpackage

@@ design/sorted_occurrence_counter_core.sv @@
`timescale 1ns / 1ps
// load item: written at the edge that accepts it, busy stays low, no result
// query item: two binary searches, first for the lowest then for the highest match, each
// probe a READ step (one registered memory read) then a CMP step, at most p = ceil(log2(n+1))
// probes each; result strobe o_valid is high the cycle after the final step, and busy is
// low by then
// synchronous active-low reset clears step counter, register, strobe; store undefined, no stall
module sorted_occurrence_counter_core import soc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_action,
    input  logic [IDX_W-1:0]        i_slot,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    output logic                    o_valid,
    output logic                    o_found,
    output logic [IDX_W-1:0]        o_first_index,
    output logic [IDX_W-1:0]        o_last_index,
    output logic [CNT_W-1:0]        o_occurrences
);

    logic [KEY_W-1:0]        r_mem [STORE_DEPTH];
    logic signed [KEY_W-1:0] r_rd_data;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_entries;
    t_step                   r_step, n_step;
    logic signed [PTR_W-1:0] r_lo, r_hi, n_lo, n_hi;
    logic [IDX_W-1:0]        r_mid;
    logic [IDX_W-1:0]        r_pos, n_pos;
    logic [IDX_W-1:0]        r_first;
    logic                    r_hit, n_hit;
    logic                    r_hit_lo;
    t_uword                  uw;
    logic                    accept, query;
    logic signed [PTR_W-1:0] sum, top, mid_s;
    logic [IDX_W-1:0]        mid;
    logic                    done;
    logic                    res_found;
    logic [CNT_W-1:0]        res_cnt;

    assign busy   = (r_step != ST_IDLE);
    assign accept = start && !busy;
    assign query  = accept && (i_action == ACT_QUERY);
    assign uw     = ucode(r_step);

    assign sum   = r_lo + r_hi;
    assign mid   = sum[IDX_W:1];
    assign mid_s = $signed({2'b00, r_mid});
    assign done  = (r_lo > r_hi);
    // clamp entries_in_use to the store depth, then minus one
    assign top   = (r_entries > CNT_W'(STORE_DEPTH))
                 ? PTR_W'(STORE_DEPTH - 1)
                 : $signed({1'b0, r_entries}) - PTR_W'(1);

    // step sequencing
    always_comb begin
        n_step = r_step + t_step'(1);
        case (uw.cond)
            JC_NEXT:   n_step = r_step + t_step'(1);
            JC_ALWAYS: n_step = uw.tgt;
            JC_DONE:   if (done) n_step = uw.tgt;
            JC_QUERY:  n_step = query ? uw.tgt : r_step;
            default:   n_step = ST_IDLE;
        endcase
    end

    // search datapath
    always_comb begin
        n_lo  = r_lo;
        n_hi  = r_hi;
        n_pos = r_pos;
        n_hit = r_hit;
        case (uw.op)
            UOP_INIT, UOP_SAVE: begin
                n_lo  = '0;
                n_hi  = top;
                n_hit = 1'b0;
            end
            UOP_CMP: begin
                if (r_key == r_rd_data) begin
                    n_hit = 1'b1;
                    n_pos = r_mid;
                    if (uw.low) n_hi = mid_s - PTR_W'(1);
                    else        n_lo = mid_s + PTR_W'(1);
                end else if (r_key < r_rd_data) begin
                    n_hi = mid_s - PTR_W'(1);
                end else begin
                    n_lo = mid_s + PTR_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign res_found = r_hit_lo && r_hit && (r_pos >= r_first);
    assign res_cnt   = CNT_W'({1'b0, r_pos} - {1'b0, r_first} + (IDX_W+1)'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= ST_IDLE;
            r_entries <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_step  <= n_step;
            o_valid <= (uw.op == UOP_FIN);
            if (i_cfg_we) r_entries <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_action == ACT_LOAD)) r_mem[i_slot] <= i_key;
        if (uw.op == UOP_READ) r_rd_data <= r_mem[mid];
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_pos <= n_pos;
        r_hit <= n_hit;
        if (query) r_key <= i_key;
        if (uw.op == UOP_READ) r_mid <= mid;
        if (uw.op == UOP_SAVE) begin
            r_first  <= r_pos;
            r_hit_lo <= r_hit;
        end
        if (uw.op == UOP_FIN) begin
            o_found       <= res_found;
            o_first_index <= res_found ? r_first : '0;
            o_last_index  <= res_found ? r_pos : '0;
            o_occurrences <= res_found ? res_cnt : '0;
        end
    end

    a_valid_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without a finished search");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_QUERY) |=> busy)
        else $error("query item did not start the sequencer");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |->
        (o_first_index == '0 && o_last_index == '0 && o_occurrences == '0))
        else $error("miss result carries nonzero fields");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |->
        (o_occurrences == CNT_W'({1'b0, o_last_index} - {1'b0, o_first_index}
                                 + (IDX_W+1)'(1))))
        else $error("occurrence count does not match index span");

endmodule
